// ----- rtl/foipc_pkg.sv -----
// ----------------------------------------------------------------------------
// foipc_pkg
// Shared types, constants and tables for the fourth-order IIR position
// controller: control word layout, coefficient table and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package foipc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COEF_FRAC        = 14;
    localparam int GAIN_FRAC        = 12;
    localparam int COEF_W           = 16;
    localparam int SCOEF_W          = 18;
    localparam int GAIN_W           = 16;
    localparam int SETPOINT_W       = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int HIST_DEPTH       = 4;
    localparam int STEP_W           = 4;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE = 4'd0;
    localparam step_t STEP_FIN  = 4'd13;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN_WAIT,
        COND_OUT_WAIT
    } cond_t;

    typedef enum logic [3:0] {
        CF_B4, CF_B3, CF_B2, CF_B1, CF_B0,
        CF_A3, CF_A2, CF_A1, CF_A0
    } coef_sel_t;

    typedef enum logic [3:0] {
        TAP_E0, TAP_E1, TAP_E2, TAP_E3, TAP_E4,
        TAP_Y1, TAP_Y2, TAP_Y3, TAP_Y4
    } tap_t;

    typedef struct packed {
        logic      in_ready;
        logic      err_en;
        logic      coef_en;
        logic      coef_scale;
        coef_sel_t coef_sel;
        logic      mul_en;
        tap_t      tap;
        logic      acc_en;
        logic      fin;
        cond_t     cond;
        logic      jump;
        step_t     target;
    } ctrl_t;

    // Q2.14 coefficients; denominator terms are stored negated so the
    // accumulator only ever adds.
    function automatic logic signed [COEF_W-1:0] coef_rom(input coef_sel_t sel);
        logic signed [COEF_W-1:0] c;
        begin
            case (sel)
                CF_B4:   c = 16'sd2323;
                CF_B3:   c = 16'sd2802;
                CF_B2:   c = -16'sd5633;
                CF_B1:   c = -16'sd5323;
                CF_B0:   c = 16'sd5849;
                CF_A3:   c = 16'sd5210;
                CF_A2:   c = 16'sd14231;
                CF_A1:   c = -16'sd148;
                CF_A0:   c = -16'sd2910;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/foipc_seq.sv -----
// ----------------------------------------------------------------------------
// foipc_seq
// Microcode sequencer: step counter, control store and wait/jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module foipc_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            out_busy,
    output foipc_pkg::ctrl_t     ctrl,
    output logic                 advance
);

    foipc_pkg::step_t step_reg;
    foipc_pkg::step_t step_next;
    logic             hold;

    function automatic foipc_pkg::ctrl_t rom(input foipc_pkg::step_t s);
        foipc_pkg::ctrl_t w;
        begin
            w = '0;
            w.cond     = foipc_pkg::COND_NONE;
            w.coef_sel = foipc_pkg::CF_B4;
            w.tap      = foipc_pkg::TAP_E0;
            w.target   = foipc_pkg::STEP_IDLE;
            case (s)
                4'd0:
                begin
                    w.in_ready = 1'b1;
                    w.cond     = foipc_pkg::COND_IN_WAIT;
                end
                4'd1:
                begin
                    w.err_en = 1'b1;
                end
                4'd2:
                begin
                    w.coef_en = 1'b1; w.coef_scale = 1'b1; w.coef_sel = foipc_pkg::CF_B4;
                end
                4'd3:
                begin
                    w.coef_en = 1'b1; w.coef_scale = 1'b1; w.coef_sel = foipc_pkg::CF_B3;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_E0;
                end
                4'd4:
                begin
                    w.coef_en = 1'b1; w.coef_scale = 1'b1; w.coef_sel = foipc_pkg::CF_B2;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_E1; w.acc_en = 1'b1;
                end
                4'd5:
                begin
                    w.coef_en = 1'b1; w.coef_scale = 1'b1; w.coef_sel = foipc_pkg::CF_B1;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_E2; w.acc_en = 1'b1;
                end
                4'd6:
                begin
                    w.coef_en = 1'b1; w.coef_scale = 1'b1; w.coef_sel = foipc_pkg::CF_B0;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_E3; w.acc_en = 1'b1;
                end
                4'd7:
                begin
                    w.coef_en = 1'b1; w.coef_sel = foipc_pkg::CF_A3;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_E4; w.acc_en = 1'b1;
                end
                4'd8:
                begin
                    w.coef_en = 1'b1; w.coef_sel = foipc_pkg::CF_A2;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_Y1; w.acc_en = 1'b1;
                end
                4'd9:
                begin
                    w.coef_en = 1'b1; w.coef_sel = foipc_pkg::CF_A1;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_Y2; w.acc_en = 1'b1;
                end
                4'd10:
                begin
                    w.coef_en = 1'b1; w.coef_sel = foipc_pkg::CF_A0;
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_Y3; w.acc_en = 1'b1;
                end
                4'd11:
                begin
                    w.mul_en = 1'b1; w.tap = foipc_pkg::TAP_Y4; w.acc_en = 1'b1;
                end
                4'd12:
                begin
                    w.acc_en = 1'b1;
                end
                4'd13:
                begin
                    w.fin    = 1'b1;
                    w.cond   = foipc_pkg::COND_OUT_WAIT;
                    w.jump   = 1'b1;
                    w.target = foipc_pkg::STEP_IDLE;
                end
                default:
                begin
                    w.jump   = 1'b1;
                    w.target = foipc_pkg::STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

    always_comb
    begin
        ctrl = rom(step_reg);
        case (ctrl.cond)
            foipc_pkg::COND_IN_WAIT:  hold = !in_valid;
            foipc_pkg::COND_OUT_WAIT: hold = out_busy;
            default:                  hold = 1'b0;
        endcase
        advance = !hold;
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (ctrl.jump)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= foipc_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fourth_order_iir_position_controller_top.sv -----
// ----------------------------------------------------------------------------
// fourth_order_iir_position_controller_top
// Fourth-order direct-form-I controller: measured angle in, angle reference out.
// ----------------------------------------------------------------------------
// One input item per control period: s_axis_tdata carries the wheel angle
// sample, s_axis_tuser marks it as new. Each item yields exactly one result
// on m_axis (saturated angle reference). Settings are to be written on the
// cfg port only while the block is idle; the block itself does not enforce it.
// A microcoded sequence of 14 steps runs per item: an accept step, an
// error step, then the nine taps pass one per cycle through a coefficient
// stage (numerator gain scaling), a shared multiplier and an accumulator,
// and a final round/saturate step. As the multiplier is shared, the block
// takes no new item until the sequence for the last one has run through;
// m_axis_tvalid rises as the final step completes.
// The result sits in an output register; the next item is accepted while
// it waits, and the final step holds if that result is still not taken.
// A new sample is latched after the result is formed, so it first shows in
// the next item's result.
// Reset clears the sample, error and output history, setpoint = 0,
// gain = 1.0 (Q4.12) and measurement disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module fourth_order_iir_position_controller_top #(
    parameter int SAMPLE_WIDTH = foipc_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // measured_angle
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // sample_valid
    input  wire logic                                  s_axis_tuser,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // angle_reference
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [foipc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [foipc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = foipc_pkg::SCOEF_W;
    localparam int PW  = SW + CW;
    localparam int AW  = SW + CW + 4;
    localparam int EW  = ((SW > foipc_pkg::SETPOINT_W) ? SW : foipc_pkg::SETPOINT_W) + 1;
    localparam int SPW = foipc_pkg::COEF_W + foipc_pkg::GAIN_W;

    localparam logic signed [SW-1:0]  SAT_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]  SAT_MIN   = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [AW-1:0]  ROUND_ACC = AW'(1) << (foipc_pkg::COEF_FRAC - 1);
    localparam logic signed [SPW-1:0] ROUND_SC  = SPW'(1) << (foipc_pkg::GAIN_FRAC - 1);

    foipc_pkg::ctrl_t ctrl;
    logic             advance;
    logic             out_busy;
    logic             in_fire;
    logic             fin_fire;

    logic signed [foipc_pkg::SETPOINT_W-1:0] setpoint_reg;
    logic signed [foipc_pkg::GAIN_W-1:0]     gain_reg;
    logic                                    meas_en_reg;

    logic signed [SW-1:0] sample_reg;
    logic                 sample_flag_reg;
    logic signed [SW-1:0] held_reg;
    logic signed [SW-1:0] e_hist_reg [foipc_pkg::HIST_DEPTH];
    logic signed [SW-1:0] y_hist_reg [foipc_pkg::HIST_DEPTH];
    logic signed [SW-1:0] e0_reg;
    logic signed [SW-1:0] e0_next;
    logic signed [CW-1:0] coef_reg;
    logic signed [CW-1:0] coef_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [SW-1:0] out_data_reg;
    logic signed [SW-1:0] out_next;
    logic                 out_valid_reg;

    logic signed [EW-1:0]                   diff;
    logic signed [foipc_pkg::COEF_W-1:0]    coef_raw;
    logic signed [SPW-1:0]                  scale_sum;
    logic signed [SW-1:0]                   tap_val;
    logic signed [AW-1:0]                   acc_rnd;
    logic signed [AW-1:0]                   acc_shift;

    foipc_seq u_foipc_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .advance  (advance)
    );

    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign s_axis_tready = ctrl.in_ready;
    assign in_fire       = ctrl.in_ready && s_axis_tvalid;
    assign fin_fire      = ctrl.fin && advance;
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata           = '0;
        m_axis_tdata[SW-1:0]   = out_data_reg;
    end

    // error, saturated to the sample range
    always_comb
    begin
        diff = EW'(setpoint_reg) - EW'(held_reg);
        if ((&diff[EW-1:SW-1]) || !(|diff[EW-1:SW-1]))
        begin
            e0_next = diff[SW-1:0];
        end
        else if (diff[EW-1])
        begin
            e0_next = SAT_MIN;
        end
        else
        begin
            e0_next = SAT_MAX;
        end
    end

    // coefficient stage: numerator taps are scaled by the gain, rounded half up
    always_comb
    begin
        coef_raw  = foipc_pkg::coef_rom(ctrl.coef_sel);
        scale_sum = coef_raw * gain_reg + ROUND_SC;
        if (ctrl.coef_scale)
        begin
            coef_next = scale_sum[foipc_pkg::GAIN_FRAC +: CW];
        end
        else
        begin
            coef_next = CW'(coef_raw);
        end
    end

    always_comb
    begin
        case (ctrl.tap)
            foipc_pkg::TAP_E0: tap_val = e0_reg;
            foipc_pkg::TAP_E1: tap_val = e_hist_reg[0];
            foipc_pkg::TAP_E2: tap_val = e_hist_reg[1];
            foipc_pkg::TAP_E3: tap_val = e_hist_reg[2];
            foipc_pkg::TAP_E4: tap_val = e_hist_reg[3];
            foipc_pkg::TAP_Y1: tap_val = y_hist_reg[0];
            foipc_pkg::TAP_Y2: tap_val = y_hist_reg[1];
            foipc_pkg::TAP_Y3: tap_val = y_hist_reg[2];
            foipc_pkg::TAP_Y4: tap_val = y_hist_reg[3];
            default:           tap_val = '0;
        endcase
        prod_next = coef_reg * tap_val;
        acc_next  = acc_reg + AW'(prod_reg);
    end

    // round half up to the sample format, then saturate
    always_comb
    begin
        acc_rnd   = acc_reg + ROUND_ACC;
        acc_shift = acc_rnd >>> foipc_pkg::COEF_FRAC;
        if ((&acc_shift[AW-1:SW-1]) || !(|acc_shift[AW-1:SW-1]))
        begin
            out_next = acc_shift[SW-1:0];
        end
        else if (acc_shift[AW-1])
        begin
            out_next = SAT_MIN;
        end
        else
        begin
            out_next = SAT_MAX;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg      <= s_axis_tdata[SW-1:0];
            sample_flag_reg <= s_axis_tuser;
        end
        if (ctrl.err_en)
        begin
            e0_reg  <= e0_next;
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.coef_en)
        begin
            coef_reg <= coef_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (fin_fire)
        begin
            out_data_reg <= out_next;
        end
    end

    // settings, history and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= '0;
            gain_reg      <= foipc_pkg::GAIN_RESET;
            meas_en_reg   <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < foipc_pkg::HIST_DEPTH; i++)
            begin
                e_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    foipc_pkg::REG_SETPOINT: setpoint_reg <= cfg_data[foipc_pkg::SETPOINT_W-1:0];
                    foipc_pkg::REG_GAIN:     gain_reg     <= cfg_data[foipc_pkg::GAIN_W-1:0];
                    foipc_pkg::REG_ENABLE:   meas_en_reg  <= cfg_data[0];
                    default:                 ;
                endcase
            end
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
                e_hist_reg[0] <= e0_reg;
                y_hist_reg[0] <= out_next;
                for (int i = 1; i < foipc_pkg::HIST_DEPTH; i++)
                begin
                    e_hist_reg[i] <= e_hist_reg[i-1];
                    y_hist_reg[i] <= y_hist_reg[i-1];
                end
                if (meas_en_reg && sample_flag_reg)
                begin
                    held_reg <= sample_reg;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/foipc_checker.sv -----
// ----------------------------------------------------------------------------
// foipc_checker
// Port-level checks for the position controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module foipc_checker #(
    parameter int SAMPLE_WIDTH = foipc_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready
);

    logic in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // one item in flight: no second accept right after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // a result is pending by the end of the sequence
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##14 m_axis_tvalid)
        else $error("no result 14 cycles after an accepted item");

    // a new result only appears while the input side is closed
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised while input side was open");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind fourth_order_iir_position_controller_top foipc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_foipc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the fourth-order IIR position controller: a scoreboard
// predicts every angle reference from the sample items and settings, with
// random source gaps and sink stalls, across directed and random setting sets.
// ----------------------------------------------------------------------------

module tb;

    import foipc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Q2.14 numerator and denominator taps of the difference equation
    localparam longint NUM_B0 = 5849;
    localparam longint NUM_B1 = -5323;
    localparam longint NUM_B2 = -5633;
    localparam longint NUM_B3 = 2802;
    localparam longint NUM_B4 = 2323;
    localparam longint DEN_A0 = 2910;
    localparam longint DEN_A1 = 148;
    localparam longint DEN_A2 = -14231;
    localparam longint DEN_A3 = -5210;

    localparam longint SAMPLE_MAX = 64'sd2147483647;
    localparam longint SAMPLE_MIN = -64'sd2147483648;

    localparam int RANDOM_ITEMS = 1628;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [31:0] angle;
        logic        fresh;
    } sample_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // controller model state and settings
    logic signed [31:0] setpoint_q;
    logic signed [15:0] gain_q;
    logic               enable_q;
    logic signed [31:0] held_q;
    longint             err_hist[4];
    longint             ref_hist[4];

    sample_item_t pending_samples[$];
    logic [31:0]  expected_refs[$];

    logic        steady_flow = 1'b0;
    logic        in_taken = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          idle_cycles = 0;
    int          error_count = 0;
    logic [31:0] want_ref;

    fourth_order_iir_position_controller_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint clamp_sample(input longint x);
        begin
            if (x > SAMPLE_MAX)
                return SAMPLE_MAX;
            if (x < SAMPLE_MIN)
                return SAMPLE_MIN;
            return x;
        end
    endfunction

    // Q2.14 tap times Q4.12 gain, rounded half up back to Q2.14
    function automatic longint scale_tap(input longint c);
        begin
            return (c * longint'(gain_q) + 2048) >>> 12;
        end
    endfunction

    // Run one control period and return the angle reference it produces.
    function automatic logic [31:0] advance_controller(input logic [31:0] angle,
                                                       input logic fresh);
        longint err;
        longint acc;
        longint y;
        int     k;
        begin
            err = clamp_sample(longint'(setpoint_q) - longint'(held_q));
            acc = scale_tap(NUM_B4) * err + scale_tap(NUM_B3) * err_hist[0]
                + scale_tap(NUM_B2) * err_hist[1] + scale_tap(NUM_B1) * err_hist[2]
                + scale_tap(NUM_B0) * err_hist[3]
                - DEN_A3 * ref_hist[0] - DEN_A2 * ref_hist[1]
                - DEN_A1 * ref_hist[2] - DEN_A0 * ref_hist[3];
            y = clamp_sample((acc + 8192) >>> 14);
            for (k = 3; k > 0; k--)
            begin
                err_hist[k] = err_hist[k-1];
                ref_hist[k] = ref_hist[k-1];
            end
            err_hist[0] = err;
            ref_hist[0] = y;
            // a new sample only shows in the next period
            if (enable_q && fresh)
                held_q = angle;
            return y[31:0];
        end
    endfunction

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (steady_flow || r < 55)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    // source side and sink stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    s_axis_tdata <= pending_samples[0].angle;
                    s_axis_tuser <= pending_samples[0].fresh;
                    s_axis_tvalid <= 1'b1;
                    void'(pending_samples.pop_front());
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // scoreboard: retire results first, then predict for the accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_refs.size() == 0)
                begin
                    error_count = error_count + 1;
                    $display("%0t: angle_reference expected none actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want_ref = expected_refs.pop_front();
                    if (m_axis_tdata !== want_ref)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: angle_reference expected %h actual %h",
                                 $time, want_ref, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_refs.push_back(advance_controller(s_axis_tdata, s_axis_tuser));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            case (idx)
                REG_SETPOINT: setpoint_q = data;
                REG_GAIN:     gain_q = data[15:0];
                REG_ENABLE:   enable_q = data[0];
                default:      ;
            endcase
            @(negedge clk);
            cfg_wr_en <= 1'b0;
        end
    endtask

    task automatic queue_sample(input logic [31:0] angle, input logic fresh);
        sample_item_t it;
        begin
            it.angle = angle;
            it.fresh = fresh;
            pending_samples.push_back(it);
        end
    endtask

    // hold off until every result is in and the block has gone quiet
    task automatic wait_drained();
        begin
            while (pending_samples.size() > 0 || expected_refs.size() > 0 || s_axis_tvalid)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] random_angle();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                return setpoint_q + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            if (r < 85)
                return $urandom;
            case ($urandom_range(0, 3))
                0:       return 32'h7fff_ffff;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
    endfunction

    task automatic random_settings();
        int          r;
        logic [15:0] g;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                write_setting(REG_SETPOINT, $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
            else if (r < 80)
                write_setting(REG_SETPOINT, $urandom);
            else
                write_setting(REG_SETPOINT, r[0] ? 32'h7fff_ffff : 32'h8000_0000);
            r = $urandom_range(0, 99);
            if (r < 40)
                g = 16'(4096 + $urandom_range(0, 1024) - 512);
            else if (r < 70)
                g = 16'($urandom);
            else
                case ($urandom_range(0, 3))
                    0:       g = 16'h8000;
                    1:       g = 16'h7fff;
                    2:       g = 16'h0000;
                    default: g = 16'h1000;
                endcase
            // upper bits of the write data are don't-care for the gain
            write_setting(REG_GAIN, {16'($urandom), g});
            write_setting(REG_ENABLE, {31'($urandom), ($urandom_range(0, 4) != 0)});
            if ($urandom_range(0, 4) == 0)
                write_setting(REG_SPARE, $urandom);
        end
    endtask

    initial
    begin
        int sent;
        int batch;
        int k;
        setpoint_q = '0;
        gain_q = GAIN_RESET;
        enable_q = 1'b0;
        held_q = '0;
        for (k = 0; k < 4; k++)
        begin
            err_hist[k] = 0;
            ref_hist[k] = 0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: samples arrive while measurement is disabled
        queue_sample(32'h7fff_ffff, 1'b1);
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'hffff_ffff, 1'b1);
        wait_drained();

        // error overflow upward, gain at its top, output overflow follows
        write_setting(REG_SETPOINT, 32'h7fff_ffff);
        write_setting(REG_GAIN, 32'h0000_7fff);
        write_setting(REG_ENABLE, 32'h0000_0001);
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h1234_5678, 1'b0);
        queue_sample(32'h7fff_ffff, 1'b1);
        queue_sample(32'h0000_0000, 1'b1);
        wait_drained();

        // error overflow downward, most negative gain, unknown index ignored
        write_setting(REG_SETPOINT, 32'h8000_0000);
        write_setting(REG_GAIN, 32'hffff_8000);
        write_setting(REG_SPARE, 32'hffff_ffff);
        queue_sample(32'h7fff_ffff, 1'b1);
        queue_sample(32'h7fff_ffff, 1'b1);
        queue_sample(32'h5555_5555, 1'b1);
        queue_sample(32'haaaa_aaaa, 1'b0);
        wait_drained();

        // zero gain and disabled measurement: only the poles act
        write_setting(REG_ENABLE, 32'hffff_fffe);
        write_setting(REG_SETPOINT, 32'h0000_0000);
        write_setting(REG_GAIN, 32'h0000_0000);
        queue_sample(32'h7fff_ffff, 1'b1);
        queue_sample(32'h0000_0001, 1'b1);
        queue_sample(32'h0000_0000, 1'b0);
        wait_drained();

        // unity gain, small step around the setpoint
        write_setting(REG_GAIN, 32'h0000_1000);
        write_setting(REG_ENABLE, 32'h0000_0001);
        write_setting(REG_SETPOINT, 32'h0001_0000);
        queue_sample(32'h0000_8000, 1'b1);
        queue_sample(32'h0001_8000, 1'b1);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h0001_0000, 1'b1);
        queue_sample(32'hffff_0000, 1'b1);
        queue_sample(32'h0002_0000, 1'b0);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            random_settings();
            steady_flow = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(60, 140);
            if (batch > RANDOM_ITEMS - sent)
                batch = RANDOM_ITEMS - sent;
            for (k = 0; k < batch; k++)
                queue_sample(random_angle(), ($urandom_range(0, 99) < 85));
            sent = sent + batch;
            wait_drained();
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
